// ===== rtl/core/buffer_free_list_allocator_defines.svh =====
// Assertion macros used by the buffer free list allocator top level.
`ifndef BUFFER_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define BUFFER_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while the synchronous reset is asserted.
`define BFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the synchronous reset is asserted.
`define BFL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bfl_pkg.sv =====
// Package with the types and constants of the buffer free list allocator.
package bfl_pkg;

    localparam int POOL_SIZE  = 64;
    localparam int IDX_W      = $clog2(POOL_SIZE);
    localparam int LINK_W     = IDX_W + 1;
    localparam int FREE_IDX_W = 7;
    localparam int ALLOC_W    = 6;

    // End-of-list marker held in a link or in the head register.
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SIZE);

    // Operation codes of a request.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [FREE_IDX_W-1:0] free_index;
    } t_req;

    typedef struct packed {
        logic               granted;
        logic [ALLOC_W-1:0] alloc_index;
        logic               pool_empty;
    } t_rsp;

    // Write and read request to the link memory.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_link_req;

endpackage

// ===== rtl/core/bfl_link_ram.sv =====
// Link memory of the free list with per-entry written flags.
module bfl_link_ram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfl_pkg::t_link_req         i_req,
    output logic [bfl_pkg::LINK_W-1:0] o_rdata
);

    logic [bfl_pkg::LINK_W-1:0]    r_mem [bfl_pkg::POOL_SIZE];
    logic [bfl_pkg::POOL_SIZE-1:0] r_valid;
    logic [bfl_pkg::LINK_W-1:0]    r_rd_data;
    logic                          r_rd_written;
    logic [bfl_pkg::IDX_W-1:0]     r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data    <= r_mem[i_req.raddr];
            r_rd_written <= r_valid[i_req.raddr];
            r_rd_addr    <= i_req.raddr;
        end
    end

    // An entry never written reads as its reset link, the next entry up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_written ? r_rd_data
                                  : ({1'b0, r_rd_addr} + bfl_pkg::LINK_W'(1));

endmodule

// ===== rtl/core/buffer_free_list_allocator.sv =====
// Top level of the buffer free list allocator: control, head register and results.
//
//  Channel   Ports                        Transaction taken when
//  --------  ---------------------------  ---------------------------------
//  request   start, busy, i_req           start is high and busy is low
//  result    o_strobe, o_rsp              o_strobe is high (one cycle only)
//
// A granted allocation reads the link of the head buffer from the synchronous
// link memory in ST_IDLE and installs it as the new head in ST_READ, while busy
// is high. A free, an ignored free and an allocation on an empty pool are
// handled in ST_IDLE alone. Each result appears on the cycle after its
// request's work ends. Reset leaves every buffer free and chained in
// ascending order; the link memory needs no clearing pass, as per-entry
// written flags supply the reset links. The receiver cannot stall.
module buffer_free_list_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bfl_pkg::t_req i_req,
    output logic          o_strobe,
    output bfl_pkg::t_rsp o_rsp
);

    `include "buffer_free_list_allocator_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic [bfl_pkg::LINK_W-1:0] r_head, n_head;
    logic                       r_strobe, n_strobe;
    bfl_pkg::t_rsp              r_rsp, n_rsp;

    bfl_pkg::t_link_req         link_req;
    logic [bfl_pkg::LINK_W-1:0] link_rdata;
    logic                       accept;
    logic                       head_none;
    logic                       free_in_range;

    bfl_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (link_req),
        .o_rdata (link_rdata)
    );

    assign busy          = (r_state == ST_READ);
    assign accept        = start && !busy;
    assign head_none     = (r_head >= bfl_pkg::LINK_NONE);
    assign free_in_range =
        ({1'b0, i_req.free_index} < (bfl_pkg::FREE_IDX_W + 1)'(bfl_pkg::POOL_SIZE));

    // A push writes the old head into the freed entry and makes that entry the
    // head. A pop reads the head's link and installs it in the next cycle. The
    // memory is never read and written in the same cycle, and the read of a
    // just-pushed entry happens in a later cycle than its write, so no
    // forwarding is needed.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;

        link_req.we    = 1'b0;
        link_req.waddr = i_req.free_index[bfl_pkg::IDX_W-1:0];
        link_req.wdata = r_head;
        link_req.re    = 1'b0;
        link_req.raddr = r_head[bfl_pkg::IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_strobe          = 1'b1;
                    n_rsp.granted     = 1'b0;
                    n_rsp.alloc_index = '0;
                    n_rsp.pool_empty  = head_none;
                    if (i_req.func == bfl_pkg::FUNC_ALLOC) begin
                        if (!head_none) begin
                            link_req.re = 1'b1;
                            n_strobe    = 1'b0;
                            n_state     = ST_READ;
                        end
                    end else if (free_in_range) begin
                        link_req.we      = 1'b1;
                        n_head           = {1'b0, i_req.free_index[bfl_pkg::IDX_W-1:0]};
                        n_rsp.granted    = 1'b1;
                        n_rsp.pool_empty = 1'b0;
                    end
                end
            end
            ST_READ: begin
                n_head            = link_rdata;
                n_strobe          = 1'b1;
                n_rsp.granted     = 1'b1;
                n_rsp.alloc_index = bfl_pkg::ALLOC_W'(r_head[bfl_pkg::IDX_W-1:0]);
                n_rsp.pool_empty  = (link_rdata >= bfl_pkg::LINK_NONE);
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `BFL_ASSERT_NXT(a_read_gives_grant, i_clk, i_rst_n, r_state == ST_READ,
        o_strobe && o_rsp.granted, "a link read did not end in a granted result")

    `BFL_ASSERT_NXT(a_busy_one_cycle, i_clk, i_rst_n, busy, !busy,
        "busy was held for more than one cycle")

    `BFL_ASSERT_IMP(a_strobe_has_cause, i_clk, i_rst_n, o_strobe,
        $past(accept || r_state == ST_READ), "result strobe without a transaction")

    `BFL_ASSERT_IMP(a_ram_port_excl, i_clk, i_rst_n, link_req.re,
        !link_req.we, "link memory read and written in one cycle")

endmodule
